// ===== rtl/core/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the Schroeder allpass filter core.
// ----------------------------------------------------------------------------
package sap_pkg;

	localparam int DEFAULT_MAX_DELAY   = 4096;
	localparam int DEFAULT_SAMPLE_BITS = 16;

	localparam int GAIN_BITS = 16;
	localparam int GAIN_FRAC = 15;
	localparam int DLEN_BITS = 13;
	localparam int CFG_BITS  = 16;
	localparam int IDX_BITS  = 1;

	localparam logic [IDX_BITS-1:0] REG_GAIN         = 1'd0;
	localparam logic [IDX_BITS-1:0] REG_DELAY_LENGTH = 1'd1;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET         = 16'd22938;
	localparam logic [DLEN_BITS-1:0] DELAY_LENGTH_RESET = 13'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_SUM1,
		ST_MUL2,
		ST_SUM2
	} sap_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // take sample, read delay line
		logic mul1;   // g * d
		logic sum1;   // w = sat(x + round(g*d))
		logic mul2;   // g * w, write w back, advance pointer
		logic sum2;   // y = sat(round(g*w) - d) into output register
	} sap_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} sap_stat_t;

endpackage

// ===== rtl/core/schroeder_allpass_filter_core.sv =====
// Steps: an accepted beat passes ST_MUL1, ST_SUM1, ST_MUL2 and ST_SUM2, which
// holds for a free output and registers m_tvalid. The next sample is taken only
// after that: the single shared multiplier and rounding adder are used twice in
// series after the delay-line read. Reset: clears pointer, fill mark, m_tvalid;
// unwritten entries read as zero via the fill mark; no clearing pass is needed.
// ----------------------------------------------------------------------------
// schroeder_allpass_filter_core
// Schroeder allpass section, direct form II, with a circular delay line.
// ----------------------------------------------------------------------------
module schroeder_allpass_filter_core
	import sap_pkg::*;
#(
	parameter int MAX_DELAY   = DEFAULT_MAX_DELAY,
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [DW-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] sample_in, rest zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [DW-1:0]       m_tdata    // [SAMPLE_BITS-1:0] sample_out, rest zero
);

	sap_cmd_t                cmd;
	sap_stat_t               stat;
	logic [SAMPLE_BITS-1:0]  sample_out;

	sap_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	sap_datapath #(
		.MAX_DELAY  (MAX_DELAY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_in (s_tdata[SAMPLE_BITS-1:0]),
		.sample_out(sample_out),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	assign m_tdata = DW'(sample_out);

endmodule

// ===== rtl/core/sap_ram.sv =====
// ----------------------------------------------------------------------------
// sap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/sap_ctrl.sv =====
// ----------------------------------------------------------------------------
// sap_ctrl
// Sequencer of the allpass section: steps one sample through read,
// two multiply/round passes and the output load.
// ----------------------------------------------------------------------------
module sap_ctrl
	import sap_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  sap_stat_t stat,
	output sap_cmd_t  cmd
);

	sap_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_SUM1;
			ST_SUM1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_SUM2;
			ST_SUM2: begin
				// hold until the output register can take the result
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_SUM1: cmd.sum1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_SUM2: cmd.sum2 = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/sap_datapath.sv =====
// ----------------------------------------------------------------------------
// sap_datapath
// Configuration registers, delay line, pointer, shared multiplier,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module sap_datapath
	import sap_pkg::*;
#(
	parameter int MAX_DELAY   = DEFAULT_MAX_DELAY,
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sap_cmd_t               cmd,
	output sap_stat_t              stat,
	input  logic                   cfg_we,
	input  logic [IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_BITS-1:0]    cfg_data,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic [SAMPLE_BITS-1:0] sample_out,
	output logic                   out_valid,
	input  logic                   out_ready
);

	localparam int SB  = SAMPLE_BITS;
	localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int FW  = $clog2(MAX_DELAY + 1);
	localparam int LW  = (FW > DLEN_BITS) ? FW : DLEN_BITS;
	localparam int PW  = GAIN_BITS + SB;
	localparam int RW  = PW + 1;
	localparam int SCW = SB + 2;
	localparam int XW  = SB + 3;

	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_DELAY);
	localparam logic [LW-1:0] LEN_ONE = LW'(1);
	localparam logic signed [RW-1:0] HALF_LSB = RW'(1) <<< (GAIN_FRAC - 1);
	localparam logic signed [XW-1:0] SAT_MAX = {4'b0000, {(SB-1){1'b1}}};
	localparam logic signed [XW-1:0] SAT_MIN = {4'b1111, {(SB-1){1'b0}}};

	logic signed [GAIN_BITS-1:0] gain_q;
	logic [DLEN_BITS-1:0]        delay_length_q;
	logic [AW-1:0]               ptr_q;
	logic [FW-1:0]               fill_q;
	logic                        rd_valid_q;
	logic signed [SB-1:0]        x_q;
	logic signed [SB-1:0]        d_q;
	logic signed [SB-1:0]        w_q;
	logic signed [PW-1:0]        prod_q;
	logic [SB-1:0]               out_q;
	logic                        out_valid_q;

	logic [LW-1:0]        len_eff;
	logic [AW-1:0]        ptr_norm;
	logic [LW-1:0]        ptr_inc;
	logic [AW-1:0]        ptr_next;
	logic [SB-1:0]        rdata;
	logic signed [SB-1:0] d_rd;
	logic signed [SB-1:0] mul_b;
	logic signed [PW-1:0] prod_d;
	logic signed [RW-1:0] rsum;
	logic signed [SCW-1:0] scaled;
	logic signed [XW-1:0] sum_wide;
	logic signed [SB-1:0] sum_sat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q         <= GAIN_RESET;
			delay_length_q <= DELAY_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:         gain_q <= cfg_data[GAIN_BITS-1:0];
				REG_DELAY_LENGTH: delay_length_q <= cfg_data[DLEN_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// effective length: zero acts as one, clamp to the line size
	always_comb begin
		len_eff = LW'(delay_length_q);
		if (len_eff == '0) len_eff = LEN_ONE;
		if (len_eff > LEN_MAX) len_eff = LEN_MAX;
	end

	assign ptr_norm = (LW'(ptr_q) >= len_eff) ? '0 : ptr_q;
	assign ptr_inc  = LW'(ptr_q) + LEN_ONE;
	assign ptr_next = (ptr_inc >= len_eff) ? '0 : ptr_inc[AW-1:0];

	// pointer and fill mark; entries at or above the mark were never written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (cmd.load) begin
			ptr_q <= ptr_norm;
		end else if (cmd.mul2) begin
			ptr_q <= ptr_next;
			if (FW'(ptr_q) == fill_q) fill_q <= fill_q + FW'(1);
		end
	end

	sap_ram #(
		.WIDTH(SB),
		.DEPTH(MAX_DELAY)
	) u_line (
		.clk  (clk),
		.we   (cmd.mul2),
		.waddr(ptr_q),
		.wdata(w_q),
		.re   (cmd.load),
		.raddr(ptr_norm),
		.rdata(rdata)
	);

	assign d_rd  = rd_valid_q ? signed'(rdata) : '0;
	assign mul_b = cmd.mul1 ? d_rd : w_q;
	assign prod_d = PW'(gain_q) * PW'(mul_b);

	// round half up: add half an LSB and shift
	assign rsum   = RW'(prod_q) + HALF_LSB;
	assign scaled = SCW'(rsum >>> GAIN_FRAC);

	assign sum_wide = cmd.sum1 ? (XW'(x_q) + XW'(scaled)) : (XW'(scaled) - XW'(d_q));

	always_comb begin
		if (sum_wide > SAT_MAX) begin
			sum_sat = SAT_MAX[SB-1:0];
		end else if (sum_wide < SAT_MIN) begin
			sum_sat = SAT_MIN[SB-1:0];
		end else begin
			sum_sat = sum_wide[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q        <= sample_in;
			rd_valid_q <= FW'(ptr_norm) < fill_q;
		end
		if (cmd.mul1) begin
			d_q <= d_rd;
		end
		if (cmd.mul1 || cmd.mul2) begin
			prod_q <= prod_d;
		end
		if (cmd.sum1) begin
			w_q <= sum_sat;
		end
		if (cmd.sum2) begin
			out_q <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.sum2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign sample_out    = out_q;

endmodule

// ===== tb/sv/schroeder_allpass_filter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schroeder_allpass_filter_core_tb
// Self-checking bench for the allpass section: a directed table of samples
// and register writes, then random phases of gain/length settings with
// bursts of samples. Each output beat is compared against a table value or
// an in-bench direct form II model with its own delay line, under random gaps
// on the input stream and random back-pressure on the output stream.
// ----------------------------------------------------------------------------
module schroeder_allpass_filter_core_tb
	import sap_pkg::*;
();

	localparam int LINE_DEPTH   = 4096;
	localparam int RAND_SAMPLES = 1150;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_GAIN,
		ROW_LEN
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [15:0] value;
		bit          known;
		logic [15:0] want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;   // [15:0] sample_in
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;   // [15:0] sample_out

	// model state
	logic signed [15:0] model_line [0:LINE_DEPTH-1];
	int unsigned        model_pos;
	logic signed [15:0] model_gain;
	logic [12:0]        model_len;

	logic [15:0] pending_y [$];
	dir_row_t    dir_rows [$];

	int  n_errors   = 0;
	int  n_samples  = 0;
	int  n_checked  = 0;
	int  n_settings = 0;
	int  stall_left = 0;
	bit  tx_calm    = 1'b0;
	bit  rx_calm    = 1'b0;

	schroeder_allpass_filter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		n_errors++;
	endtask

	// round(g*v / 2^15), half toward plus infinity
	function automatic longint round_q15(input longint g, input longint v);
		longint t;
		t = g * v + 64'sd16384;
		return t >>> 15;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] allpass_predict(input logic signed [15:0] x);
		int unsigned len;
		longint      d;
		longint      w;
		longint      y;
		len = model_len;
		if (len == 0) begin
			len = 1;
		end
		if (len > LINE_DEPTH) begin
			len = LINE_DEPTH;
		end
		// pointer left behind by a shortened line restarts at zero
		if (model_pos >= len) begin
			model_pos = 0;
		end
		d = model_line[model_pos];
		w = clamp16(x + round_q15(model_gain, d));
		y = clamp16(round_q15(model_gain, w) - d);
		model_line[model_pos] = w[15:0];
		model_pos++;
		if (model_pos >= len) begin
			model_pos = 0;
		end
		return y[15:0];
	endfunction

	function automatic int pick_gap();
		int r;
		if (tx_calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// keep tvalid high across back-to-back beats; lower it only for a gap
	task automatic send_sample(input logic [15:0] x, input int gap, input bit known,
			input logic [15:0] want);
		logic [15:0] y;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		do @(posedge clk); while (!s_tready);
		y = allpass_predict(x);
		pending_y.push_back(known ? want : y);
		n_samples++;
	endtask

	task automatic drain_pipe();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_y.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_GAIN:         model_gain = data;
			REG_DELAY_LENGTH: model_len  = data[12:0];
			default:          ;
		endcase
		n_settings++;
	endtask

	task automatic add_row(input row_kind_t kind, input logic [15:0] value, input bit known,
			input logic [15:0] want);
		dir_row_t row;
		row.kind  = kind;
		row.value = value;
		row.known = known;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	// output back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
			m_tready   <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// output checker
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (pending_y.size() == 0) begin
				flag_error($sformatf("unexpected output beat %h", m_tdata));
			end else begin
				want = pending_y.pop_front();
				if (m_tdata !== want) begin
					flag_error($sformatf("sample_out got %h want %h", m_tdata, want));
				end
			end
		end
	end

	initial begin
		int          left;
		int          burst;
		int          r;
		logic [15:0] g;
		logic [15:0] len;
		logic [15:0] x;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		foreach (model_line[i]) begin
			model_line[i] = '0;
		end
		model_pos  = 0;
		model_gain = GAIN_RESET;
		model_len  = DELAY_LENGTH_RESET;

		// line is all zeros after reset
		add_row(ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000);
		add_row(ROW_SAMPLE, 16'h7FFF, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h8000, 1'b0, '0);
		// zero gain: w = x, y = -d
		add_row(ROW_GAIN,   16'h0000, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h1234, 1'b1, 16'h0000);
		// shorten the line below the pointer
		add_row(ROW_LEN,    16'h0001, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h8000, 1'b1, 16'h0000);
		add_row(ROW_SAMPLE, 16'h0005, 1'b1, 16'h7FFF);
		// zero length behaves as one
		add_row(ROW_LEN,    16'h0000, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h0000, 1'b1, 16'hFFFB);
		// full positive gain, length above the line size
		add_row(ROW_GAIN,   16'h7FFF, 1'b0, '0);
		add_row(ROW_LEN,    16'hFFFF, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h7FFF, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h8000, 1'b0, '0);
		add_row(ROW_LEN,    16'h0002, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h7FFF, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h8000, 1'b0, '0);
		// gain of exactly -1.0
		add_row(ROW_GAIN,   16'h8000, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h7FFF, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h8000, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h7FFF, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h0000, 1'b0, '0);
		add_row(ROW_GAIN,   16'h8001, 1'b0, '0);
		add_row(ROW_LEN,    16'h1000, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'hFFFF, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h0001, 1'b0, '0);
		add_row(ROW_SAMPLE, 16'h8000, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_SAMPLE: send_sample(dir_rows[i].value, pick_gap(), dir_rows[i].known,
					dir_rows[i].want);
				ROW_GAIN: begin
					drain_pipe();
					write_reg(REG_GAIN, dir_rows[i].value);
				end
				default: begin
					drain_pipe();
					write_reg(REG_DELAY_LENGTH, dir_rows[i].value);
				end
			endcase
		end

		left = RAND_SAMPLES;
		while (left > 0) begin
			drain_pipe();
			r = $urandom_range(0, 99);
			tx_calm = (r < 15);
			rx_calm = (r < 10 || r > 92);

			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					g = 16'h7FFF;
				end else if (r < 8) begin
					g = 16'h8001;
				end else if (r < 11) begin
					g = 16'h8000;
				end else if (r < 13) begin
					g = 16'h0000;
				end else begin
					g = 16'($urandom_range(0, 65535));
				end
				write_reg(REG_GAIN, g);
			end

			if ($urandom_range(0, 2) != 0) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					len[12:0] = 13'($urandom_range(1, 16));
				end else if (r < 80) begin
					len[12:0] = 13'($urandom_range(17, 300));
				end else if (r < 88) begin
					len[12:0] = 13'd0;
				end else if (r < 95) begin
					len[12:0] = 13'($urandom_range(4097, 8191));
				end else begin
					len[12:0] = 13'($urandom_range(3000, 4096));
				end
				// bits above the register width are don't-care
				len[15:13] = 3'($urandom_range(0, 7));
				write_reg(REG_DELAY_LENGTH, len);
			end

			burst = $urandom_range(20, 120);
			if (burst > left) begin
				burst = left;
			end
			repeat (burst) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					x = 16'($urandom_range(0, 65535));
				end else if (r < 80) begin
					x = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
				end else begin
					x = 16'($signed($urandom_range(0, 512)) - 256);
				end
				send_sample(x, pick_gap(), 1'b0, '0);
			end
			left -= burst;
		end

		rx_calm = 1'b0;
		drain_pipe();
		if (pending_y.size() != 0) begin
			flag_error($sformatf("%0d output beats never arrived", pending_y.size()));
		end

		$display("Checked %0d of %0d samples across %0d register writes, %0d mismatches.",
			n_checked, n_samples, n_settings, n_errors);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sap_pkg.sv
rtl/core/sap_ram.sv
rtl/core/sap_ctrl.sv
rtl/core/sap_datapath.sv
rtl/core/schroeder_allpass_filter_core.sv
tb/sv/schroeder_allpass_filter_core_tb.sv
